// File: hw/rtl/lns_pkg.sv
// lns_pkg: shared types, widths and constants of the lif neuron step unit
// used by lns_front, lns_back and the top level, depends on nothing
`default_nettype none

package lns_pkg;

	// field and state widths
	localparam int SPIKE_W   = 16;
	localparam int WIDX_W    = 4;
	localparam int WEIGHT_W  = 10;
	localparam int THRESH_W  = 14;
	localparam int ACTIVE_W  = 5;
	localparam int SUM_W     = 14;  // 16 spike lanes of at most 1023
	localparam int MEMB_W    = 15;
	localparam int STEP_W    = 8;
	localparam int FACTOR_W  = 11;
	localparam int FRAC_BITS = 10;
	localparam int PROD_W    = MEMB_W + FACTOR_W;
	localparam int DECAY_K_W = STEP_W - 1;

	localparam logic [MEMB_W-1:0] MEMBRANE_MAX = '1;
	localparam logic [STEP_W-1:0] STEP_MAX     = '1;

	// item kinds
	localparam logic KIND_WEIGHT = 1'b0;
	localparam logic KIND_STEP   = 1'b1;

	// configuration register indexes
	localparam logic CFG_IDX_W = 1;
	localparam logic REG_FIRE_THRESHOLD = 1'b0;
	localparam logic REG_ACTIVE_INPUTS  = 1'b1;

	localparam logic [THRESH_W-1:0] FIRE_THRESHOLD_RST = 14'd1792;  // 1.75 in Q4.10
	localparam logic [ACTIVE_W-1:0] ACTIVE_INPUTS_RST  = 5'd10;

	// round(1024*exp(-k)), all later entries are zero
	localparam int DECAY_NZ = 8;
	localparam logic [FACTOR_W-1:0] DECAY_Q10 [DECAY_NZ] = '{
		11'd1024, 11'd377, 11'd139, 11'd51, 11'd19, 11'd7, 11'd3, 11'd1
	};

	// beat from the front to the back queue
	typedef struct packed {
		logic             push;
		logic [SUM_W-1:0] sum;
	} step_beat_t;

	// one result item
	typedef struct packed {
		logic              fire;
		logic [MEMB_W-1:0] potential;
	} result_t;

	function automatic logic [FACTOR_W-1:0] decay_lookup(input logic [DECAY_K_W-1:0] k);
		logic [FACTOR_W-1:0] f;
		f = '0;
		if (k < DECAY_K_W'(DECAY_NZ)) begin
			f = DECAY_Q10[k[2:0]];
		end
		return f;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lns_fifo.sv
// lns_fifo: small register queue with full/empty flags
// generic in width and depth, no package dependency
`default_nettype none

module lns_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lns_front.sv
// lns_front: weight table and masked synapse sum for accepted items
// uses lns_pkg
`default_nettype none

module lns_front
	import lns_pkg::*;
#(
	parameter int MAX_INPUTS = 16
) (
	input  wire logic                clk,
	input  wire logic                accept,
	input  wire logic                kind,
	input  wire logic [WIDX_W-1:0]   weight_index,
	input  wire logic [WEIGHT_W-1:0] weight_value,
	input  wire logic [SPIKE_W-1:0]  spikes,
	input  wire logic [ACTIVE_W-1:0] active_inputs,
	output step_beat_t               beat
);

	// only the first 16 synapses can ever see a spike
	localparam int NLANE = (MAX_INPUTS < SPIKE_W) ? MAX_INPUTS : SPIKE_W;
	localparam int IDX_EXT_W = 7;

	logic [WEIGHT_W-1:0]  weights_q [MAX_INPUTS];
	logic [IDX_EXT_W-1:0] idx_ext;
	logic                 wr_en;
	logic [SUM_W-1:0]     sum;

	assign idx_ext = IDX_EXT_W'(weight_index);
	assign wr_en   = accept && (kind == KIND_WEIGHT);

	// index past the table is dropped
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_INPUTS; j++) begin
			if (wr_en && (idx_ext == IDX_EXT_W'(j))) begin
				weights_q[j] <= weight_value;
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int j = 0; j < NLANE; j++) begin
			if (spikes[j] && (ACTIVE_W'(j) < active_inputs)) begin
				sum = sum + SUM_W'(weights_q[j]);
			end
		end
	end

	assign beat.push = accept && (kind == KIND_STEP);
	assign beat.sum  = sum;

endmodule

`default_nettype wire

// File: hw/rtl/lns_back.sv
// lns_back: membrane decay, integrate, threshold and step counter
// uses lns_pkg; takes sums from the front queue, feeds the result queue
`default_nettype none

module lns_back
	import lns_pkg::*;
#(
	parameter int DECAY_ENTRIES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                mid_empty,
	input  wire logic [SUM_W-1:0]    mid_sum,
	input  wire logic                res_full,
	input  wire logic [THRESH_W-1:0] fire_threshold,
	output logic                     mid_pop,
	output logic                     res_push,
	output result_t                  res
);

	logic [MEMB_W-1:0]    membrane_q;
	logic [STEP_W-1:0]    steps_q;
	logic                 step_go;
	logic [DECAY_K_W-1:0] k;
	logic [FACTOR_W-1:0]  factor;
	logic [PROD_W-1:0]    prod;
	logic [MEMB_W+1:0]    integ;
	logic [MEMB_W-1:0]    memb_sat;
	logic                 fire_d;
	logic [MEMB_W-1:0]    memb_next;
	logic [STEP_W-1:0]    steps_inc;

	assign step_go  = !mid_empty && !res_full;
	assign mid_pop  = step_go;
	assign res_push = step_go;

	assign k      = steps_q[STEP_W-1:1];
	assign factor = (k >= DECAY_K_W'(DECAY_ENTRIES)) ? '0 : decay_lookup(k);
	assign prod   = PROD_W'(membrane_q) * PROD_W'(factor);
	assign integ  = (MEMB_W+2)'(prod[PROD_W-1:FRAC_BITS]) + (MEMB_W+2)'(mid_sum);
	assign memb_sat = (integ > (MEMB_W+2)'(MEMBRANE_MAX)) ? MEMBRANE_MAX
		: integ[MEMB_W-1:0];

	// zero sum leaves the membrane alone and cannot fire
	assign fire_d    = (mid_sum != '0) && (memb_sat > MEMB_W'(fire_threshold));
	assign memb_next = (mid_sum == '0) ? membrane_q : (fire_d ? '0 : memb_sat);
	assign steps_inc = (steps_q == STEP_MAX) ? steps_q : steps_q + 1'b1;

	assign res.fire      = fire_d;
	assign res.potential = memb_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			membrane_q <= '0;
			steps_q    <= '0;
		end else if (step_go) begin
			membrane_q <= memb_next;
			steps_q    <= fire_d ? STEP_W'(1) : steps_inc;
		end
	end

`ifndef ASSERT_OFF
	a_fire_restarts_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && fire_d) |=> (steps_q == STEP_W'(1) && membrane_q == '0))
		else $error("step counter or membrane not cleared after firing");

	a_zero_sum_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && mid_sum == '0) |=> (membrane_q == $past(membrane_q)))
		else $error("membrane changed on a step with zero sum");

	a_count_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && !fire_d) |=>
		(steps_q == STEP_W'($past(steps_q) + 1'b1) || steps_q == STEP_MAX))
		else $error("step counter did not advance");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lif_neuron_step_unit.sv
// lif_neuron_step_unit: top level of the leaky integrate-and-fire neuron
// uses lns_pkg, lns_front, lns_fifo and lns_back
//
// usage
//   input channel is a queue push side: a beat is taken at a rising edge with
//   push high and full low. kind selects a weight write (weight_index,
//   weight_value) or a time step (spikes). weight writes give no result.
//   result channel is a queue pop side: while empty is low, fire and
//   potential show the oldest result; pop high at a rising edge takes it.
//   cfg_write with cfg_index/cfg_data sets fire_threshold (index 0) or
//   active_inputs (index 1); write only while the unit is idle.
// timing
//   a step beat taken at a rising edge enters the front queue; the back
//   end pops it, updates the membrane (multiply by the decay factor, add,
//   saturate, compare, all combinational) and pushes the result into the
//   result queue. one beat per cycle is sustained while pop stays high.
// reset
//   arst_n clears membrane, step counter, queues and loads the register
//   defaults (threshold 1.75, ten inputs); the weight table is not cleared.
// stalls
//   when pop stays low the result queue fills, the back end holds, the
//   front queue fills and full rises; no beat is lost or repeated.
`default_nettype none

module lif_neuron_step_unit
	import lns_pkg::*;
#(
	parameter int MAX_INPUTS    = 16,
	parameter int DECAY_ENTRIES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input queue side
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 kind,
	input  wire logic [WIDX_W-1:0]    weight_index,
	input  wire logic [WEIGHT_W-1:0]  weight_value,
	input  wire logic [SPIKE_W-1:0]   spikes,
	// result queue side
	output logic                      empty,
	input  wire logic                 pop,
	output logic                      fire,
	output logic      [MEMB_W-1:0]    potential,
	// configuration write port
	input  wire logic                 cfg_write,
	input  wire logic                 cfg_index,
	input  wire logic [THRESH_W-1:0]  cfg_data
);

	localparam int QDEPTH = 2;  // two entries keep one beat per cycle flowing

	logic [THRESH_W-1:0] fire_threshold_q;
	logic [ACTIVE_W-1:0] active_inputs_q;
	logic                accept;
	step_beat_t          beat;
	logic                mid_full, mid_empty, mid_pop;
	logic [SUM_W-1:0]    mid_sum;
	logic                res_push, res_full;
	result_t             res_in, res_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_threshold_q <= FIRE_THRESHOLD_RST;
			active_inputs_q  <= ACTIVE_INPUTS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FIRE_THRESHOLD: fire_threshold_q <= cfg_data;
				REG_ACTIVE_INPUTS:  active_inputs_q  <= cfg_data[ACTIVE_W-1:0];
				default: ;
			endcase
		end
	end

	// full follows the step queue, weight writes wait with it to keep order
	assign full   = mid_full;
	assign accept = push && !mid_full;

	// front: weight table and masked sum of spiking synapses
	lns_front #(
		.MAX_INPUTS(MAX_INPUTS)
	) u_front (
		.clk          (clk),
		.accept       (accept),
		.kind         (kind),
		.weight_index (weight_index),
		.weight_value (weight_value),
		.spikes       (spikes),
		.active_inputs(active_inputs_q),
		.beat         (beat)
	);

	// queue of step sums between front and back
	lns_fifo #(
		.WIDTH(SUM_W),
		.DEPTH(QDEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (beat.push),
		.wdata (beat.sum),
		.pop   (mid_pop),
		.rdata (mid_sum),
		.full  (mid_full),
		.empty (mid_empty)
	);

	// back: decay, integrate and fire
	lns_back #(
		.DECAY_ENTRIES(DECAY_ENTRIES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mid_empty     (mid_empty),
		.mid_sum       (mid_sum),
		.res_full      (res_full),
		.fire_threshold(fire_threshold_q),
		.mid_pop       (mid_pop),
		.res_push      (res_push),
		.res           (res_in)
	);

	// result queue parts the back end from the receiver
	lns_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QDEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.pop   (pop),
		.rdata (res_out),
		.full  (res_full),
		.empty (empty)
	);

	assign fire      = res_out.fire;
	assign potential = res_out.potential;

`ifndef ASSERT_OFF
	a_fire_zero_potential: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && fire) |-> (potential == '0))
		else $error("fired result with nonzero potential");

	a_weight_beat_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_WEIGHT) |-> !beat.push)
		else $error("weight write entered the step queue");

	a_step_beat_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_STEP) |-> beat.push)
		else $error("accepted step beat not queued");
`endif

endmodule

`default_nettype wire
